[rtl/core/npbs_pkg.sv]
`timescale 1ns / 1ps

package npbs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int LEVEL_COUNT   = 16;

    localparam int ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam int INDEX_W   = 8;
    localparam int CHAN_W    = 8;
    localparam int ENTRY_W   = 3 * CHAN_W;
    localparam int LEVEL_W   = 4;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int BLEND_W   = SQ_W + LEVEL_W;
    localparam int DSQ_W     = 2 * BLEND_W;
    localparam int ERR_W     = 42;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVEL_COUNT - 1);
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(PALETTE_DEPTH);

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAL_COUNT  = 2'd3;

    typedef struct packed {
        logic              accept_load;
        logic              accept_query;
        logic              src_read;
        logic              src_square;
        logic              blend_calc;
        logic              scan_init;
        logic              scan_issue;
        logic [ADDR_W-1:0] scan_addr;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic              quick;
        logic              pipe_busy;
        logic [ADDR_W-1:0] last_addr;
    } dp_status_t;

endpackage

[rtl/core/npbs_ram.sv]
`timescale 1ns / 1ps

module npbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/npbs_ctrl.sv]
`timescale 1ns / 1ps

module npbs_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_cmd,
    output logic                   in_ready,
    input  logic                   out_ready,
    output logic                   out_valid,
    input  npbs_pkg::dp_status_t   st,
    output npbs_pkg::ctrl_cmd_t    cm
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRC_RD,
        S_SRC_SQ,
        S_BLEND,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    logic [npbs_pkg::ADDR_W-1:0] cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        cm             = '0;
        cm.scan_addr   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == npbs_pkg::CMD_QUERY)
                    begin
                        cm.accept_query = 1'b1;
                        state_next      = st.quick ? S_FINISH : S_SRC_RD;
                    end
                    else
                    begin
                        cm.accept_load = 1'b1;
                    end
                end
            end
            S_SRC_RD:
            begin
                cm.src_read = 1'b1;
                state_next  = S_SRC_SQ;
            end
            S_SRC_SQ:
            begin
                cm.src_square = 1'b1;
                state_next    = S_BLEND;
            end
            S_BLEND:
            begin
                cm.blend_calc = 1'b1;
                cm.scan_init  = 1'b1;
                cnt_next      = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cm.scan_issue = 1'b1;
                if (cnt_reg == st.last_addr)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + npbs_pkg::ADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!st.pipe_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cm.out_load    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/npbs_dpath.sv]
`timescale 1ns / 1ps

module npbs_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  npbs_pkg::ctrl_cmd_t              cm,
    output npbs_pkg::dp_status_t             st,
    input  logic                             cfg_we,
    input  logic [npbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npbs_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic [npbs_pkg::INDEX_W-1:0]     entry_index,
    input  logic [npbs_pkg::CHAN_W-1:0]      red,
    input  logic [npbs_pkg::CHAN_W-1:0]      green,
    input  logic [npbs_pkg::CHAN_W-1:0]      blue,
    input  logic [npbs_pkg::LEVEL_W-1:0]     level,
    output logic [npbs_pkg::INDEX_W-1:0]     best_index,
    output logic [npbs_pkg::ERR_W-1:0]       best_error,
    output logic                             out_of_range
);

    localparam int AW = npbs_pkg::ADDR_W;
    localparam int CW = npbs_pkg::CHAN_W;
    localparam int SW = npbs_pkg::SQ_W;
    localparam int BW = npbs_pkg::BLEND_W;
    localparam int DW = npbs_pkg::DSQ_W;
    localparam int EW = npbs_pkg::ERR_W;

    // configuration
    logic [CW-1:0]                   base_r_reg, base_g_reg, base_b_reg;
    logic [npbs_pkg::COUNT_W-1:0]    pal_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_r_reg    <= '0;
            base_g_reg    <= '0;
            base_b_reg    <= '0;
            pal_count_reg <= npbs_pkg::DEPTH_CNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                npbs_pkg::CFG_BASE_RED:   base_r_reg    <= cfg_data[CW-1:0];
                npbs_pkg::CFG_BASE_GREEN: base_g_reg    <= cfg_data[CW-1:0];
                npbs_pkg::CFG_BASE_BLUE:  base_b_reg    <= cfg_data[CW-1:0];
                npbs_pkg::CFG_PAL_COUNT:  pal_count_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // query decode
    logic [npbs_pkg::COUNT_W-1:0] eff_count, eff_m1;
    logic                         in_oor;
    logic [npbs_pkg::LEVEL_W-1:0] level_sat;

    assign eff_count = (pal_count_reg > npbs_pkg::DEPTH_CNT) ? npbs_pkg::DEPTH_CNT
                                                             : pal_count_reg;
    assign eff_m1    = eff_count - npbs_pkg::COUNT_W'(1);
    assign in_oor    = npbs_pkg::COUNT_W'(entry_index) >= eff_count;
    assign level_sat = (level > npbs_pkg::LEVEL_MAX) ? npbs_pkg::LEVEL_MAX : level;

    assign st.quick     = in_oor || (level_sat == '0);
    assign st.last_addr = eff_m1[AW-1:0];

    // palette store
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [npbs_pkg::ENTRY_W-1:0] ram_rdata;
    logic [AW-1:0]     qidx_reg;
    logic [npbs_pkg::LEVEL_W-1:0] qlvl_reg;

    assign ram_we    = cm.accept_load &&
                       (npbs_pkg::COUNT_W'(entry_index) < npbs_pkg::DEPTH_CNT);
    assign ram_re    = cm.src_read | cm.scan_issue;
    assign ram_raddr = cm.src_read ? qidx_reg : cm.scan_addr;

    npbs_ram #(
        .WIDTH (npbs_pkg::ENTRY_W),
        .DEPTH (npbs_pkg::PALETTE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_index[AW-1:0]),
        .wdata ({red, green, blue}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // blend target, three channels in squared space
    logic [SW-1:0] src_sq_reg  [3];
    logic [SW-1:0] base_sq_reg [3];
    logic [BW-1:0] blend_reg   [3];
    logic [CW-1:0] rd_chan     [3];
    logic [CW-1:0] base_chan   [3];

    assign rd_chan[0]   = ram_rdata[3*CW-1:2*CW];
    assign rd_chan[1]   = ram_rdata[2*CW-1:CW];
    assign rd_chan[2]   = ram_rdata[CW-1:0];
    assign base_chan[0] = base_r_reg;
    assign base_chan[1] = base_g_reg;
    assign base_chan[2] = base_b_reg;

    // scan pipeline
    logic          v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic [SW-1:0] sq1_reg  [3];
    logic [BW-1:0] d2_reg   [3];
    logic [DW-1:0] dsq3_reg [3];
    logic [EW-1:0] err4_reg;
    logic          found_reg;

    logic [npbs_pkg::INDEX_W-1:0] bidx_reg;
    logic [EW-1:0]                berr_reg;
    logic                         boor_reg;
    logic [npbs_pkg::INDEX_W-1:0] oidx_reg;
    logic [EW-1:0]                oerr_reg;
    logic                         ooor_reg;

    logic [BW-1:0] tgt  [3];
    logic [BW-1:0] diff [3];
    logic          take;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            tgt[c]  = BW'(sq1_reg[c]) * BW'(npbs_pkg::LEVEL_MAX);
            diff[c] = (blend_reg[c] >= tgt[c]) ? (blend_reg[c] - tgt[c])
                                               : (tgt[c] - blend_reg[c]);
        end
    end

    assign take         = v4_reg && (!found_reg || (err4_reg < berr_reg));
    assign st.pipe_busy = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cm.scan_issue;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cm.scan_init)
            begin
                found_reg <= 1'b0;
            end
            else if (v4_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cm.accept_query)
        begin
            qidx_reg <= entry_index[AW-1:0];
            qlvl_reg <= level_sat;
            bidx_reg <= in_oor ? '0 : entry_index;
            berr_reg <= '0;
            boor_reg <= in_oor;
        end
        else if (cm.scan_init)
        begin
            boor_reg <= 1'b0;
        end
        else if (take)
        begin
            bidx_reg <= npbs_pkg::INDEX_W'(t4_reg);
            berr_reg <= err4_reg;
        end

        for (int c = 0; c < 3; c++)
        begin
            if (cm.src_square)
            begin
                src_sq_reg[c]  <= SW'(rd_chan[c]) * SW'(rd_chan[c]);
                base_sq_reg[c] <= SW'(base_chan[c]) * SW'(base_chan[c]);
            end
            if (cm.blend_calc)
            begin
                blend_reg[c] <= BW'(npbs_pkg::LEVEL_MAX - qlvl_reg) * BW'(src_sq_reg[c])
                              + BW'(qlvl_reg) * BW'(base_sq_reg[c]);
            end
            sq1_reg[c]  <= SW'(rd_chan[c]) * SW'(rd_chan[c]);
            d2_reg[c]   <= diff[c];
            dsq3_reg[c] <= DW'(d2_reg[c]) * DW'(d2_reg[c]);
        end

        t0_reg   <= cm.scan_addr;
        t1_reg   <= t0_reg;
        t2_reg   <= t1_reg;
        t3_reg   <= t2_reg;
        t4_reg   <= t3_reg;
        err4_reg <= EW'(dsq3_reg[0]) + EW'(dsq3_reg[1]) + EW'(dsq3_reg[2]);

        if (cm.out_load)
        begin
            oidx_reg <= bidx_reg;
            oerr_reg <= berr_reg;
            ooor_reg <= boor_reg;
        end
    end

    assign best_index   = oidx_reg;
    assign best_error   = oerr_reg;
    assign out_of_range = ooor_reg;

endmodule

[rtl/core/nearest_palette_blend_search.sv]
`timescale 1ns / 1ps

// nearest palette entry to a color blended toward a base color
// input channel: valid/ready beats; cmd load writes {red, green, blue} at
//   entry_index (no result), cmd query runs a search
// query: source entry blended with the base color in squared space by level,
//   then every entry below palette_count is scored; lowest error wins, ties
//   keep the lowest index; one result beat per query
// config channel: cfg_valid/cfg_ready beats, always ready; user must write
//   only idle, unenforced; index 0..2 base red/green/blue, 3 palette_count
// quick path: out-of-range or level 0 queries skip the scan and go straight
//   to the result; a full search reads one entry per cycle from the single
//   read port of the palette ram into a five stage error pipe and drains it
// flow: one query at a time; loads are taken back to back while idle
// reset: base colors 0, palette_count 256, no result pending; the palette
//   ram is not cleared and must be loaded before use
// stall: a finished result holds in the output register; new items are taken
//   meanwhile, and a later result waits until the held beat is taken
module nearest_palette_blend_search (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             cmd,
    input  logic [npbs_pkg::INDEX_W-1:0]     entry_index,
    input  logic [npbs_pkg::CHAN_W-1:0]      red,
    input  logic [npbs_pkg::CHAN_W-1:0]      green,
    input  logic [npbs_pkg::CHAN_W-1:0]      blue,
    input  logic [npbs_pkg::LEVEL_W-1:0]     level,
    // results
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [npbs_pkg::INDEX_W-1:0]     best_index,
    output logic [npbs_pkg::ERR_W-1:0]       best_error,
    output logic                             out_of_range,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [npbs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npbs_pkg::CFG_DAT_W-1:0]   cfg_data
);

    npbs_pkg::ctrl_cmd_t  cm;
    npbs_pkg::dp_status_t st;

    // config registers accept a write every cycle
    assign cfg_ready = 1'b1;

    // sequencer: accept, source read, square, blend, scan, drain, result hand-off
    npbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_cmd    (cmd),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .st        (st),
        .cm        (cm)
    );

    // palette ram, blend math, error pipe, best tracker, output register
    npbs_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cm           (cm),
        .st           (st),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .level        (level),
        .best_index   (best_index),
        .best_error   (best_error),
        .out_of_range (out_of_range)
    );

endmodule
